### rtl/qeb_pkg.sv
// qeb_pkg: shared constants, types and the full-step decode table for the
// quadrature encoder bank. No dependencies; used by every rtl file.
package qeb_pkg;

   localparam int CHANNELS = 9;
   localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_W   = 4;
   localparam int CNT_W    = 8;
   localparam int ST_W     = 3;
   localparam int DIR_W    = 2;
   localparam int MASK_W   = 16;

   localparam logic [ST_W-1:0] ST_START     = 3'd0;
   localparam logic [ST_W-1:0] ST_CW_FINAL  = 3'd1;
   localparam logic [ST_W-1:0] ST_CW_BEGIN  = 3'd2;
   localparam logic [ST_W-1:0] ST_CW_NEXT   = 3'd3;
   localparam logic [ST_W-1:0] ST_CCW_BEGIN = 3'd4;
   localparam logic [ST_W-1:0] ST_CCW_FINAL = 3'd5;
   localparam logic [ST_W-1:0] ST_CCW_NEXT  = 3'd6;

   localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic [DIR_W-1:0] dir;
      logic [ST_W-1:0]  next;
   } step_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic emit_lo;
      logic emit_hi;
      logic emit_cnt;
      logic idx_clr;
      logic idx_inc;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic free;
      logic nz_any;
      logic nz_cur;
      logic nz_more;
   } stat_type;

   function automatic step_type decode_step(input logic [ST_W-1:0] st,
                                            input logic a, input logic b);
      step_type r;
      logic [1:0] ab;
      ab     = {a, b};
      r.dir  = DIR_IDLE;
      r.next = ST_START;
      unique case (st)
         ST_CW_FINAL: begin
            case (ab)
               2'd0: r.next = ST_CW_NEXT;
               2'd1: r.next = ST_START;
               2'd2: r.next = ST_CW_FINAL;
               default: begin
                  r.next = ST_START;
                  r.dir  = DIR_CW;
               end
            endcase
         end
         ST_CW_BEGIN: begin
            case (ab)
               2'd0: r.next = ST_CW_NEXT;
               2'd1: r.next = ST_CW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         ST_CW_NEXT: begin
            case (ab)
               2'd0: r.next = ST_CW_NEXT;
               2'd1: r.next = ST_CW_BEGIN;
               2'd2: r.next = ST_CW_FINAL;
               default: r.next = ST_START;
            endcase
         end
         ST_CCW_BEGIN: begin
            case (ab)
               2'd0: r.next = ST_CCW_NEXT;
               2'd2: r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         ST_CCW_FINAL: begin
            case (ab)
               2'd0: r.next = ST_CCW_NEXT;
               2'd1: r.next = ST_CCW_FINAL;
               2'd2: r.next = ST_START;
               default: begin
                  r.next = ST_START;
                  r.dir  = DIR_CCW;
               end
            endcase
         end
         ST_CCW_NEXT: begin
            case (ab)
               2'd0: r.next = ST_CCW_NEXT;
               2'd1: r.next = ST_CCW_FINAL;
               2'd2: r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
         default: begin
            // start state, and the unused code
            case (ab)
               2'd1: r.next = ST_CW_BEGIN;
               2'd2: r.next = ST_CCW_BEGIN;
               default: r.next = ST_START;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/qeb_ctrl.sv
// qeb_ctrl: sequencer for sample and report items.
// Depends on qeb_pkg; drives the datapath in qeb_dpath.
module qeb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_cmd,
   input  qeb_pkg::stat_type  stat,
   output qeb_pkg::cmd_type   cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SAMPLE = 3'd1;
   localparam logic [2:0] S_LO     = 3'd2;
   localparam logic [2:0] S_HI     = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = (req_cmd == qeb_pkg::CMD_REPORT) ? S_LO : S_SAMPLE;
            end
         end
         S_SAMPLE: begin
            if (stat.free) begin
               cmd.step = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LO: begin
            if (stat.free) begin
               cmd.emit_lo = 1'b1;
               state_in    = S_HI;
            end
         end
         S_HI: begin
            if (stat.free) begin
               cmd.emit_hi = 1'b1;
               state_in    = stat.nz_any ? S_WALK : S_IDLE;
            end
         end
         S_WALK: begin
            if (!stat.nz_cur) begin
               cmd.idx_inc = 1'b1;
            end else if (stat.free) begin
               cmd.emit_cnt = 1'b1;
               cmd.idx_inc  = 1'b1;
               if (!stat.nz_more) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/qeb_dpath.sv
// qeb_dpath: decoder states, step counters, report index and output register.
// Depends on qeb_pkg; commanded by qeb_ctrl.
module qeb_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  qeb_pkg::cmd_type            cmd,
   output qeb_pkg::stat_type           stat,
   input  logic                        req_cmd,
   input  logic [qeb_pkg::CHAN_W-1:0]  req_channel,
   input  logic                        req_phase_a,
   input  logic                        req_phase_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [qeb_pkg::CNT_W-1:0]   rsp_data_byte,
   output logic [qeb_pkg::DIR_W-1:0]   rsp_step_dir,
   output logic                        rsp_pending,
   output logic                        rsp_last
);

   localparam int CH = qeb_pkg::CHANNELS;
   localparam int IW = qeb_pkg::IDX_W;
   localparam int CW = qeb_pkg::CNT_W;

   logic                        is_report_ff;
   logic [qeb_pkg::CHAN_W-1:0]  chan_ff;
   logic                        a_ff, b_ff;
   logic [IW-1:0]               idx_ff, idx_in;

   logic [qeb_pkg::ST_W-1:0]    st_ff [CH];
   logic [CW-1:0]               cnt_ff [CH];

   logic                        valid_ff, valid_in;
   logic [CW-1:0]               data_ff, data_in;
   logic [qeb_pkg::DIR_W-1:0]   dir_ff, dir_in;
   logic                        pend_ff, pend_in;
   logic                        last_ff, last_in;

   logic [IW-1:0]               addr;
   logic                        in_range;
   logic [CW-1:0]               sel_cnt;
   logic [CW-1:0]               new_cnt;
   qeb_pkg::step_type           tab;
   logic [qeb_pkg::DIR_W-1:0]   step_dir;
   logic [CH-1:0]               nz;
   logic [CH-1:0]               nz_after;
   logic [CH-1:0]               nz_others;
   logic [qeb_pkg::MASK_W-1:0]  nz_wide;

   assign addr     = is_report_ff ? idx_ff : chan_ff[IW-1:0];
   assign in_range = ({1'b0, chan_ff} < (qeb_pkg::CHAN_W + 1)'(CH));
   assign sel_cnt  = cnt_ff[addr];
   assign tab      = qeb_pkg::decode_step(st_ff[addr], a_ff, b_ff);
   assign step_dir = in_range ? tab.dir : qeb_pkg::DIR_IDLE;
   assign nz_wide  = qeb_pkg::MASK_W'(nz);

   always_comb begin
      case (step_dir)
         qeb_pkg::DIR_CW:  new_cnt = sel_cnt + 1'b1;
         qeb_pkg::DIR_CCW: new_cnt = sel_cnt - 1'b1;
         default:          new_cnt = sel_cnt;
      endcase
   end

   always_comb begin
      for (int i = 0; i < CH; i++) begin
         nz[i]        = (cnt_ff[i] != '0);
         nz_after[i]  = (in_range && addr == IW'(i)) ? (new_cnt != '0) : nz[i];
         nz_others[i] = nz[i] && (idx_ff != IW'(i));
      end
   end

   assign stat.free    = !valid_ff || rsp_ready;
   assign stat.nz_any  = |nz;
   assign stat.nz_cur  = nz[idx_ff];
   assign stat.nz_more = |nz_others;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      dir_in   = dir_ff;
      pend_in  = pend_ff;
      last_in  = last_ff;
      if (cmd.step) begin
         valid_in = 1'b1;
         data_in  = '0;
         dir_in   = step_dir;
         pend_in  = |nz_after;
         last_in  = 1'b1;
      end else if (cmd.emit_lo) begin
         valid_in = 1'b1;
         data_in  = nz_wide[7:0];
         dir_in   = qeb_pkg::DIR_IDLE;
         pend_in  = 1'b0;
         last_in  = 1'b0;
      end else if (cmd.emit_hi) begin
         valid_in = 1'b1;
         data_in  = nz_wide[15:8];
         dir_in   = qeb_pkg::DIR_IDLE;
         pend_in  = 1'b0;
         last_in  = !(|nz);
      end else if (cmd.emit_cnt) begin
         valid_in = 1'b1;
         data_in  = sel_cnt;
         dir_in   = qeb_pkg::DIR_IDLE;
         pend_in  = 1'b0;
         last_in  = !(|nz_others);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         for (int i = 0; i < CH; i++) begin
            st_ff[i]  <= qeb_pkg::ST_START;
            cnt_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         if (cmd.step && in_range) begin
            st_ff[addr]  <= tab.next;
            cnt_ff[addr] <= new_cnt;
         end
         if (cmd.emit_cnt) begin
            cnt_ff[addr] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_report_ff <= req_cmd;
         chan_ff      <= req_channel;
         a_ff         <= req_phase_a;
         b_ff         <= req_phase_b;
      end
      data_ff <= data_in;
      dir_ff  <= dir_in;
      pend_ff <= pend_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_step_dir  = dir_ff;
   assign rsp_pending   = pend_ff;
   assign rsp_last      = last_ff;

endmodule

### rtl/quadrature_encoder_bank_unit.sv
// Quadrature encoder bank: a full-step table decoder and 8-bit wrapping count per
// channel, with a read-and-clear report. A sample word is accepted when idle;
// then, once the result register is free, that channel is updated and the result
// register loaded. A report emits the low and high mask bytes, then walks the
// counters one index per cycle, waiting on a busy result register at each nonzero
// one, which it emits and clears; the single counter read port sets that pace.
// A new word is accepted while the last result still waits on the output side.
// Depends on qeb_pkg, qeb_ctrl and qeb_dpath.
module quadrature_encoder_bank_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // channel[3:0], phase_a[4], phase_b[5], zero[7:6]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // data_byte[7:0], step_dir[9:8], zero[15:10]
   output logic        rsp_tuser,   // pending
   output logic        rsp_tlast
);

   qeb_pkg::cmd_type                cmd;
   qeb_pkg::stat_type               stat;
   logic [qeb_pkg::CNT_W-1:0]       data_byte;
   logic [qeb_pkg::DIR_W-1:0]       step_dir;

   qeb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   qeb_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_cmd       (req_tuser),
      .req_channel   (req_tdata[3:0]),
      .req_phase_a   (req_tdata[4]),
      .req_phase_b   (req_tdata[5]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_data_byte (data_byte),
      .rsp_step_dir  (step_dir),
      .rsp_pending   (rsp_tuser),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, step_dir, data_byte};

endmodule
